FILE: hdl/b64d_pkg.sv
// Shared types, constants and the character classifier of the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_EQUAL = 8'h3d;
	localparam logic [5:0] SYM_PLUS   = 6'h3e;
	localparam logic [5:0] SYM_SLASH  = 6'h3f;

	typedef enum logic [2:0] {
		KIND_SYM,
		KIND_SPACE,
		KIND_PAD,
		KIND_NUL,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] sym;
		logic       eot;
	} item_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		PHASE_ACTIVE,
		PHASE_SWALLOW
	} phase_t;

	function automatic item_t classify(input logic [7:0] c, input logic eot);
		item_t it;
		it.kind = KIND_BAD;
		it.sym  = 6'd0;
		it.eot  = eot;
		if (c >= 8'h41 && c <= 8'h5a) begin
			it.kind = KIND_SYM;
			it.sym  = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			it.kind = KIND_SYM;
			it.sym  = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			it.kind = KIND_SYM;
			it.sym  = 6'(c - 8'h30 + 8'd52);
		end else if (c == CHAR_PLUS) begin
			it.kind = KIND_SYM;
			it.sym  = SYM_PLUS;
		end else if (c == CHAR_SLASH) begin
			it.kind = KIND_SYM;
			it.sym  = SYM_SLASH;
		end else if (c == CHAR_EQUAL) begin
			it.kind = KIND_PAD;
		end else if (c == CHAR_NUL) begin
			it.kind = KIND_NUL;
		end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
			it.kind = KIND_SPACE;
		end
		return it;
	endfunction

endpackage

FILE: hdl/b64d_front.sv
// Front end: accepts characters and classifies them for the decode queue.
`timescale 1ns / 1ps

module b64d_front (
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // text_char[7:0]
	input  logic            s_tlast,   // end_of_text
	output logic            q_valid,
	input  logic            q_ready,
	output b64d_pkg::item_t q_item
);

	assign q_valid  = s_tvalid;
	assign s_tready = q_ready;
	assign q_item   = b64d_pkg::classify(s_tdata, s_tlast);

endmodule

FILE: hdl/b64d_queue.sv
// Short queue of classified characters between the front and back ends.
`timescale 1ns / 1ps

module b64d_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  b64d_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output b64d_pkg::item_t out_item
);

	b64d_pkg::item_t                   entry_q [b64d_pkg::QUEUE_DEPTH];
	logic [b64d_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [b64d_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [b64d_pkg::QUEUE_AW:0]       count_q;
	logic                              push;
	logic                              pop;

	assign in_ready  = count_q != (b64d_pkg::QUEUE_AW+1)'(b64d_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = entry_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/b64d_back.sv
// Back end: bit accumulator, byte count, final status and the output register.
`timescale 1ns / 1ps

module b64d_back #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  b64d_pkg::item_t in_item,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata,   // data_byte[7:0], status[9:8], decoded_count[25:10]
	output logic            m_tuser,   // byte_valid
	output logic            m_tlast    // done_res
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	logic [15:0]            capacity_q;
	logic [13:0]            acc_q;
	logic [3:0]             pending_q;
	logic                   pad_q;
	logic [COUNT_WIDTH-1:0] count_q;
	b64d_pkg::phase_t       phase_q;

	logic [13:0]            acc_n;
	logic [3:0]             pending_n;
	logic                   pad_n;
	logic [COUNT_WIDTH-1:0] count_n;
	b64d_pkg::phase_t       phase_n;

	logic                   res_n;
	logic [7:0]             byte_n;
	logic                   byte_valid_n;
	logic                   done_n;
	b64d_pkg::status_t      status_n;
	logic [15:0]            total_n;
	logic                   invalid;
	logic [3:0]             shamt;

	logic                   out_valid_q;
	logic [7:0]             byte_q;
	logic                   byte_valid_q;
	logic                   done_q;
	b64d_pkg::status_t      status_q;
	logic [15:0]            total_q;
	logic                   fire;

	assign in_ready = !out_valid_q || m_tready;
	assign fire     = in_valid && in_ready;

	always_comb begin
		acc_n        = acc_q;
		pending_n    = pending_q;
		pad_n        = pad_q;
		count_n      = count_q;
		phase_n      = phase_q;
		res_n        = 1'b0;
		byte_n       = 8'd0;
		byte_valid_n = 1'b0;
		done_n       = 1'b0;
		status_n     = b64d_pkg::ST_OK;
		total_n      = 16'd0;
		invalid      = 1'b0;
		shamt        = 4'd0;
		case (phase_q)
			b64d_pkg::PHASE_SWALLOW: begin
				if (in_item.eot) begin
					phase_n = b64d_pkg::PHASE_ACTIVE;
				end
			end
			b64d_pkg::PHASE_ACTIVE: begin
				case (in_item.kind)
					b64d_pkg::KIND_SYM: begin
						if (pad_q) begin
							invalid = 1'b1;
						end else begin
							acc_n     = {acc_q[7:0], in_item.sym};
							pending_n = pending_q + 4'd6;
						end
					end
					b64d_pkg::KIND_PAD: begin
						if (!pad_q) begin
							if (pending_q != 4'd0 && pending_q != 4'd6) begin
								pending_n = 4'd0;
								pad_n     = 1'b1;
							end else begin
								invalid = 1'b1;
							end
						end
					end
					b64d_pkg::KIND_SPACE, b64d_pkg::KIND_NUL: begin
					end
					default: begin
						invalid = 1'b1;
					end
				endcase
				if (invalid) begin
					res_n    = 1'b1;
					done_n   = 1'b1;
					status_n = b64d_pkg::ST_INVALID;
				end else if (pending_n >= 4'd8) begin
					shamt     = pending_n - 4'd8;
					pending_n = shamt;
					if (CMP_W'(count_q) < CMP_W'(capacity_q)) begin
						byte_valid_n = 1'b1;
						res_n        = 1'b1;
						byte_n       = 8'(acc_n >> shamt);
					end
					if (count_q != '1) begin
						count_n = count_q + 1'b1;
					end
				end
				if (!invalid && (in_item.kind == b64d_pkg::KIND_NUL || in_item.eot)) begin
					res_n    = 1'b1;
					done_n   = 1'b1;
					status_n = (CMP_W'(count_n) > CMP_W'(capacity_q)) ?
						b64d_pkg::ST_OVERFLOW : b64d_pkg::ST_OK;
					total_n  = (CMP_W'(count_n) > CMP_W'(16'hffff)) ?
						16'hffff : 16'(count_n);
				end
				if (done_n) begin
					acc_n     = '0;
					pending_n = '0;
					pad_n     = 1'b0;
					count_n   = '0;
					phase_n   = in_item.eot ? b64d_pkg::PHASE_ACTIVE : b64d_pkg::PHASE_SWALLOW;
				end
			end
			default: begin
				phase_n = b64d_pkg::PHASE_ACTIVE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64d_pkg::PHASE_ACTIVE;
		end else if (fire) begin
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= 16'hffff;
			acc_q       <= '0;
			pending_q   <= '0;
			pad_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				acc_q     <= acc_n;
				pending_q <= pending_n;
				pad_q     <= pad_n;
				count_q   <= count_n;
				if (res_n) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_n) begin
			byte_q       <= byte_n;
			byte_valid_q <= byte_valid_n;
			done_q       <= done_n;
			status_q     <= status_n;
			total_q      <= total_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, total_q, status_q, byte_q};
	assign m_tuser  = byte_valid_q;
	assign m_tlast  = done_q;

endmodule

FILE: hdl/base64_stream_decoder.sv
// Top level of the base64 stream decoder.
`timescale 1ns / 1ps

// Decodes base64 text, one character per transaction on the slave side, into bytes on the
// master side. It takes one character every clock cycle as long as the four-entry queue
// between the classifier and the decoder has room; the decoder retires one queued character
// per cycle, as long as its output register is empty or being read, through its combinational
// accumulate and extract step; a character's result passes through the queue and then the
// output register on its way to the master side. A result transaction carries a byte (tuser
// high), the final status (tlast high) or both. Whitespace is skipped, and a NUL or a
// character with tlast ends the text with its status and byte count. The capacity register
// may be written only while the decoder is idle.
module base64_stream_decoder #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,  // buffer_capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // text_char[7:0]
	input  logic        s_tlast,    // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // data_byte[7:0], status[9:8], decoded_count[25:10]
	output logic        m_tuser,    // byte_valid
	output logic        m_tlast     // done_res
);

	logic            fq_valid;
	logic            fq_ready;
	b64d_pkg::item_t fq_item;
	logic            qb_valid;
	logic            qb_ready;
	b64d_pkg::item_t qb_item;

	b64d_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_item   (fq_item)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	b64d_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (qb_valid),
		.in_ready  (qb_ready),
		.in_item   (qb_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
